[sv/pmfill_pkg.sv]
// shared constants, payload types and control encodings for the page-mode frame store fill block
`default_nettype none

package pmfill_pkg;

   localparam int MAX_WIDTH   = 128;
   localparam int MAX_HEIGHT  = 64;
   localparam int PAGES       = (MAX_HEIGHT + 7) / 8;
   localparam int STORE_DEPTH = MAX_WIDTH * PAGES;

   localparam int ADDR_BITS  = $clog2(STORE_DEPTH);
   localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
   localparam int H_BITS     = $clog2(MAX_HEIGHT + 1);
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int PAGE_BITS  = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int LIMIT_BITS = W_BITS + H_BITS;

   localparam int COORD_BITS = 16;
   localparam int SPAN_BITS  = COORD_BITS + 1;
   localparam int INDEX_BITS = 10;

   localparam int DISP_W_BITS    = 8;
   localparam int DISP_H_BITS    = 7;
   localparam int CSR_DATA_BITS  = 8;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_HEIGHT = 1'd1;

   localparam logic [DISP_W_BITS-1:0] RESET_WIDTH  = 8'd128;
   localparam logic [DISP_H_BITS-1:0] RESET_HEIGHT = 7'd64;

   localparam logic [1:0] MODE_PLOT  = 2'd0;
   localparam logic [1:0] MODE_FILL  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]                   mode;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] rect_width;
      logic signed [COORD_BITS-1:0] rect_height;
      logic                         lit;
      logic [INDEX_BITS-1:0]        byte_index;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [7:0] read_data;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_REPLY,
      JOB_FILL,
      JOB_CLEAR,
      JOB_READ
   } job_kind_type;

   typedef struct packed {
      job_kind_type         kind;
      logic                 status;
      logic                 lit;
      logic [COL_BITS-1:0]  col_lo;
      logic [COL_BITS-1:0]  col_last;
      logic [ROW_BITS-1:0]  row_lo;
      logic [ROW_BITS-1:0]  row_last;
      logic [ADDR_BITS-1:0] addr;
   } job_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_READ_RD,
      ST_READ_DONE
   } back_state_type;

endpackage

`default_nettype wire

[sv/pmfill_front.sv]
// front end: takes command beats, checks bounds, clips rectangles and forms jobs
`default_nettype none

module pmfill_front import pmfill_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              hold,
   input  wire logic              push,
   output logic                   ready,
   input  wire req_type           req,
   input  wire logic [W_BITS-1:0] w_eff,
   input  wire logic [H_BITS-1:0] h_eff,
   output logic                   q_push,
   input  wire logic              q_full,
   output job_type                q_job
);

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    accept;

   logic signed [SPAN_BITS-1:0] sx, sy, sw, sh, w_span, h_span;
   logic signed [SPAN_BITS-1:0] xe, ye, x0, y0, x1, y1, x_last, y_last;
   logic                        plot_ok, fill_some, read_ok;
   logic [LIMIT_BITS-1:0]       area;

   assign ready  = !hold && (!valid_ff || !q_full);
   assign accept = push && ready;
   assign q_push = valid_ff;
   assign q_job  = job_ff;

   always_comb begin
      sx     = $signed({req.pos_x[COORD_BITS-1], req.pos_x});
      sy     = $signed({req.pos_y[COORD_BITS-1], req.pos_y});
      sw     = $signed({req.rect_width[COORD_BITS-1], req.rect_width});
      sh     = $signed({req.rect_height[COORD_BITS-1], req.rect_height});
      w_span = $signed(SPAN_BITS'(w_eff));
      h_span = $signed(SPAN_BITS'(h_eff));

      xe     = sx + sw;
      ye     = sy + sh;
      x0     = sx[SPAN_BITS-1] ? '0 : sx;
      y0     = sy[SPAN_BITS-1] ? '0 : sy;
      x1     = (xe > w_span) ? w_span : xe;
      y1     = (ye > h_span) ? h_span : ye;
      x_last = x1 - SPAN_BITS'(1);
      y_last = y1 - SPAN_BITS'(1);

      plot_ok   = !sx[SPAN_BITS-1] && (sx < w_span) && !sy[SPAN_BITS-1] && (sy < h_span);
      fill_some = (x0 < x1) && (y0 < y1);

      area    = LIMIT_BITS'(w_eff) * LIMIT_BITS'(h_eff);
      read_ok = (32'(req.byte_index) < 32'(area >> 3)) &&
                (32'(req.byte_index) < STORE_DEPTH);

      job_in          = job_ff;
      job_in.kind     = JOB_REPLY;
      job_in.status   = 1'b0;
      job_in.lit      = req.lit;
      job_in.col_lo   = '0;
      job_in.col_last = '0;
      job_in.row_lo   = '0;
      job_in.row_last = '0;
      job_in.addr     = ADDR_BITS'(req.byte_index);

      case (req.mode)
         MODE_PLOT: begin
            if (plot_ok) begin
               job_in.kind     = JOB_FILL;
               job_in.col_lo   = COL_BITS'(sx);
               job_in.col_last = COL_BITS'(sx);
               job_in.row_lo   = ROW_BITS'(sy);
               job_in.row_last = ROW_BITS'(sy);
            end else begin
               job_in.status = 1'b1;
            end
         end
         MODE_FILL: begin
            if (fill_some) begin
               job_in.kind     = JOB_FILL;
               job_in.col_lo   = COL_BITS'(x0);
               job_in.col_last = COL_BITS'(x_last);
               job_in.row_lo   = ROW_BITS'(y0);
               job_in.row_last = ROW_BITS'(y_last);
            end
         end
         MODE_CLEAR: begin
            job_in.kind = JOB_CLEAR;
         end
         MODE_READ: begin
            if (read_ok) begin
               job_in.kind = JOB_READ;
            end else begin
               job_in.status = 1'b1;
            end
         end
         default: begin
            job_in.kind = JOB_REPLY;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (!q_full) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         job_ff <= job_in;
      end
   end

endmodule

`default_nettype wire

[sv/pmfill_queue.sv]
// short job queue between the front end and the store engine
`default_nettype none

module pmfill_queue import pmfill_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         empty
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[sv/pmfill_back.sv]
// store engine: frame store memory, clearing sweep, byte read-modify-write walk and result register
`default_nettype none

module pmfill_back import pmfill_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [W_BITS-1:0] w_eff,
   input  wire logic              q_empty,
   input  wire job_type           q_job,
   output logic                   q_pop,
   input  wire logic              rsp_pop,
   output rsp_type                rsp,
   output logic                   rsp_valid,
   output logic                   init_busy
);

   back_state_type       state_ff, state_in;
   job_type              job_ff, job_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [ADDR_BITS-1:0] sweep_ff, sweep_in;
   logic                 init_ff, init_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_set;

   logic [7:0]           store [STORE_DEPTH];
   logic [7:0]           rd_data_ff;
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_addr;
   logic [7:0]           mem_wdata;

   logic                 take;
   logic [PAGE_BITS-1:0] page_lo, page_hi, q_page_lo;
   logic [2:0]           lo_bit, hi_bit;
   logic [7:0]           mask, merged;
   logic [ADDR_BITS-1:0] fill_addr;
   logic                 last_page, last_col, sweep_last;

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;
   assign init_busy = init_ff;

   assign take       = (state_ff == ST_IDLE) && !q_empty && (!rsp_valid_ff || rsp_pop);
   assign q_pop      = take;
   assign page_lo    = PAGE_BITS'(job_ff.row_lo >> 3);
   assign page_hi    = PAGE_BITS'(job_ff.row_last >> 3);
   assign q_page_lo  = PAGE_BITS'(q_job.row_lo >> 3);
   assign last_page  = (page_ff == page_hi);
   assign last_col   = (col_ff == job_ff.col_last);
   assign sweep_last = (sweep_ff == ADDR_BITS'(STORE_DEPTH - 1));
   assign fill_addr  = ADDR_BITS'(col_ff) + ADDR_BITS'(page_ff) * ADDR_BITS'(w_eff);

   // rows of the current page that the rectangle covers
   always_comb begin
      lo_bit = (page_ff == page_lo) ? job_ff.row_lo[2:0] : 3'd0;
      hi_bit = (page_ff == page_hi) ? job_ff.row_last[2:0] : 3'd7;
      mask   = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
      merged = job_ff.lit ? (rd_data_ff | mask) : (rd_data_ff & ~mask);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               case (q_job.kind)
                  JOB_FILL:  state_in = ST_FILL_RD;
                  JOB_CLEAR: state_in = ST_SWEEP;
                  JOB_READ:  state_in = ST_READ_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL_RD: begin
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            state_in = (last_page && last_col) ? ST_IDLE : ST_FILL_RD;
         end
         ST_READ_RD: begin
            state_in = ST_READ_DONE;
         end
         ST_READ_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      job_in    = job_ff;
      col_in    = col_ff;
      page_in   = page_ff;
      sweep_in  = sweep_ff;
      init_in   = init_ff;
      rsp_in    = rsp_ff;
      rsp_set   = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = fill_addr;
      mem_wdata = merged;
      case (state_ff)
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_addr  = sweep_ff;
            mem_wdata = 8'h00;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_last) begin
               init_in = 1'b0;
               if (!init_ff) begin
                  rsp_set = 1'b1;
                  rsp_in  = '0;
               end
            end
         end
         ST_IDLE: begin
            if (take) begin
               job_in   = q_job;
               col_in   = q_job.col_lo;
               page_in  = q_page_lo;
               sweep_in = '0;
               if (q_job.kind == JOB_REPLY) begin
                  rsp_set          = 1'b1;
                  rsp_in.status    = q_job.status;
                  rsp_in.read_data = 8'h00;
               end
            end
         end
         ST_FILL_RD: begin
            mem_addr = fill_addr;
         end
         ST_FILL_WR: begin
            mem_we = 1'b1;
            if (last_page) begin
               page_in = page_lo;
               if (last_col) begin
                  rsp_set = 1'b1;
                  rsp_in  = '0;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               page_in = page_ff + 1'b1;
            end
         end
         ST_READ_RD: begin
            mem_addr = job_ff.addr;
         end
         ST_READ_DONE: begin
            mem_addr         = job_ff.addr;
            rsp_set          = 1'b1;
            rsp_in.status    = 1'b0;
            rsp_in.read_data = rd_data_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase

      if (rsp_set) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= store[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         page_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         page_ff      <= page_in;
      end
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

[sv/page_mode_mono_framebuffer_fill.sv]
// top level: page-mode one-bit frame store with plot, rectangle fill, clear and byte read
//
//   channel   ports                               beat taken when
//   command   push, full, req_data                push && !full
//   result    empty, pop, rsp_data                pop && !empty
//   csr       csr_write_en, csr_index, csr_wdata  csr_write_en
//
// a beat passes through the front register and the job queue on its way to the store engine
// plot and read in the store engine: pickup, memory read, then write or capture; a rejected one is answered at pickup
// fill: pickup, then a memory read and a write for each touched byte; answered at pickup when nothing lands on screen
// clear: pickup, then a sweep over all STORE_DEPTH bytes, one byte zeroed per cycle
// after reset the store is swept to zero, all STORE_DEPTH (1024) bytes, and full stays high meanwhile
// a held result stalls the engine; front register and job queue take up to three more beats
`default_nettype none

module page_mode_mono_framebuffer_fill import pmfill_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   output logic                           full,
   input  wire req_type                   req_data,
   output logic                           empty,
   input  wire logic                      pop,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CW_BITS = (W_BITS > DISP_W_BITS) ? W_BITS : DISP_W_BITS;
   localparam int CH_BITS = (H_BITS > DISP_H_BITS) ? H_BITS : DISP_H_BITS;

   logic [DISP_W_BITS-1:0] width_ff, width_in;
   logic [DISP_H_BITS-1:0] height_ff, height_in;
   logic [CW_BITS-1:0]     w_wide;
   logic [CH_BITS-1:0]     h_wide;
   logic [W_BITS-1:0]      w_eff;
   logic [H_BITS-1:0]      h_eff;

   logic    front_ready;
   logic    fq_push, fq_full;
   job_type fq_job;
   logic    bq_pop, bq_empty;
   job_type bq_job;
   logic    rsp_valid;
   logic    init_busy;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_DISPLAY_WIDTH:  width_in  = csr_wdata[DISP_W_BITS-1:0];
            CSR_DISPLAY_HEIGHT: height_in = csr_wdata[DISP_H_BITS-1:0];
            default:            width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // saturate the panel size at the store geometry
   always_comb begin
      w_wide = CW_BITS'(width_ff);
      h_wide = CH_BITS'(height_ff);
      w_eff  = (w_wide > CW_BITS'(MAX_WIDTH)) ? W_BITS'(MAX_WIDTH) : W_BITS'(w_wide);
      h_eff  = (h_wide > CH_BITS'(MAX_HEIGHT)) ? H_BITS'(MAX_HEIGHT) : H_BITS'(h_wide);
   end

   assign full  = !front_ready;
   assign empty = !rsp_valid;

   pmfill_front u_front (
      .clock  (clock),
      .reset  (reset),
      .hold   (init_busy),
      .push   (push),
      .ready  (front_ready),
      .req    (req_data),
      .w_eff  (w_eff),
      .h_eff  (h_eff),
      .q_push (fq_push),
      .q_full (fq_full),
      .q_job  (fq_job)
   );

   pmfill_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fq_push),
      .push_job (fq_job),
      .full     (fq_full),
      .pop      (bq_pop),
      .pop_job  (bq_job),
      .empty    (bq_empty)
   );

   pmfill_back u_back (
      .clock     (clock),
      .reset     (reset),
      .w_eff     (w_eff),
      .q_empty   (bq_empty),
      .q_job     (bq_job),
      .q_pop     (bq_pop),
      .rsp_pop   (pop && rsp_valid),
      .rsp       (rsp_data),
      .rsp_valid (rsp_valid),
      .init_busy (init_busy)
   );

endmodule

`default_nettype wire
